// ----- sv/bpc_pkg.sv -----
// ----------------------------------------------------------------------------
// bpc_pkg
// Types, codes and constants shared by the button press classifier files.
// ----------------------------------------------------------------------------
package bpc_pkg;

	localparam int unsigned TICKS_W  = 8;
	localparam int unsigned STEP_W   = 12;
	localparam int unsigned ADJ_W    = 13;
	localparam int unsigned EVENT_W  = 3;
	localparam int unsigned STATE_W  = 4;
	localparam int unsigned ADDR_W   = 4;
	localparam int unsigned DATA_W   = 32;
	localparam int unsigned IN_W     = 8;
	localparam int unsigned OUT_W    = 24;

	localparam logic [TICKS_W-1:0] LONG_TICKS_RST  = 8'd10;
	localparam logic [STEP_W-1:0]  FINE_STEP_RST   = 12'd60;
	localparam logic [STEP_W-1:0]  COARSE_STEP_RST = 12'd600;
	localparam logic [TICKS_W-1:0] HOLD_MAX        = 8'hFF;

	typedef enum logic [1:0] {
		REG_LONG_TICKS  = 2'd0,
		REG_FINE_STEP   = 2'd1,
		REG_COARSE_STEP = 2'd2,
		REG_UNUSED      = 2'd3
	} reg_idx_t;

	typedef enum logic [STATE_W-1:0] {
		ST_START    = 4'd0,
		ST_INIT     = 4'd1,
		ST_MWAIT    = 4'd2,
		ST_IDLE     = 4'd3,
		ST_UPWAIT   = 4'd4,
		ST_UP       = 4'd5,
		ST_UPRAPID  = 4'd6,
		ST_DNWAIT   = 4'd7,
		ST_DN       = 4'd8,
		ST_DNRAPID  = 4'd9,
		ST_BOTHWAIT = 4'd10,
		ST_SAVE     = 4'd11,
		ST_SAVEHOLD = 4'd12
	} state_t;

	typedef enum logic [EVENT_W-1:0] {
		EV_NONE = 3'd0,
		EV_INC  = 3'd1,
		EV_DEC  = 3'd2,
		EV_SAVE = 3'd3,
		EV_READ = 3'd4
	} event_t;

	typedef struct packed {
		logic [TICKS_W-1:0] long_press_ticks;
		logic [STEP_W-1:0]  fine_step;
		logic [STEP_W-1:0]  coarse_step;
	} cfg_t;

endpackage

// ----- sv/bpc_cfg.sv -----
// ----------------------------------------------------------------------------
// bpc_cfg
// APB register file holding the press threshold and the two step sizes.
// ----------------------------------------------------------------------------
module bpc_cfg
	import bpc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t     cfg_q;
	logic     wr_en;
	reg_idx_t idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;
	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.long_press_ticks <= LONG_TICKS_RST;
			cfg_q.fine_step        <= FINE_STEP_RST;
			cfg_q.coarse_step      <= COARSE_STEP_RST;
		end else if (wr_en) begin
			case (idx)
				REG_LONG_TICKS:  cfg_q.long_press_ticks <= pwdata[TICKS_W-1:0];
				REG_FINE_STEP:   cfg_q.fine_step        <= pwdata[STEP_W-1:0];
				REG_COARSE_STEP: cfg_q.coarse_step      <= pwdata[STEP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			REG_LONG_TICKS:  prdata = {{(DATA_W-TICKS_W){1'b0}}, cfg_q.long_press_ticks};
			REG_FINE_STEP:   prdata = {{(DATA_W-STEP_W){1'b0}}, cfg_q.fine_step};
			REG_COARSE_STEP: prdata = {{(DATA_W-STEP_W){1'b0}}, cfg_q.coarse_step};
			default:         prdata = '0;
		endcase
	end

endmodule

// ----- sv/button_press_classifier.sv -----
// Path: an accepted item passes the input register, then the result register on m_tvalid.
// Throughput: one item per cycle; the input register and the result register both
// advance whenever the result register is empty or being taken.
// Reset: arst_n clears the state machine to start, the hold counter to zero, both
// pipeline valids, and sets the registers to their defaults (10, 60, 600).
// ----------------------------------------------------------------------------
// button_press_classifier
// Classifies short, long and two-button presses into adjust and save events; a read event follows reset.
// ----------------------------------------------------------------------------
module button_press_classifier
	import bpc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [IN_W-1:0]   s_tdata,   // button_up, button_down
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_W-1:0]  m_tdata,   // event_res, adjust_seconds, machine_state
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	cfg_t cfg;

	bpc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	logic               valid_s1;
	logic               up_s1;
	logic               dn_s1;
	logic               valid_s2;
	logic [OUT_W-1:0]   data_s2;
	logic               advance;

	state_t             state_q;
	state_t             state_d;
	logic [TICKS_W-1:0] hold_q;
	logic [TICKS_W-1:0] hold_d;
	event_t             ev;
	logic [ADJ_W-1:0]   adj;

	logic none, both, only_up, only_dn, longp;

	assign advance  = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = valid_s2;
	assign m_tdata  = data_s2;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			up_s1 <= s_tdata[0];
			dn_s1 <= s_tdata[1];
		end
	end

	assign none    = !up_s1 && !dn_s1;
	assign both    = up_s1 && dn_s1;
	assign only_up = up_s1 && !dn_s1;
	assign only_dn = dn_s1 && !up_s1;
	assign longp   = hold_q >= cfg.long_press_ticks;

	// state and hold counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_START;
			hold_q  <= '0;
		end else if (valid_s1 && advance) begin
			state_q <= state_d;
			hold_q  <= hold_d;
		end
	end

	always_comb begin
		state_d = ST_MWAIT;
		case (state_q)
			ST_START: state_d = ST_INIT;
			ST_INIT:  state_d = ST_MWAIT;
			ST_MWAIT: state_d = none ? ST_IDLE : ST_MWAIT;
			ST_IDLE: begin
				if (only_up)      state_d = ST_UPWAIT;
				else if (only_dn) state_d = ST_DNWAIT;
				else if (both)    state_d = ST_BOTHWAIT;
				else              state_d = ST_IDLE;
			end
			ST_UPWAIT: begin
				if (both)        state_d = ST_BOTHWAIT;
				else if (!longp) state_d = only_up ? ST_UPWAIT : ST_UP;
				else             state_d = only_up ? ST_UPRAPID : ST_MWAIT;
			end
			ST_UP:      state_d = ST_MWAIT;
			ST_UPRAPID: state_d = only_up ? ST_UPRAPID : ST_MWAIT;
			ST_DNWAIT: begin
				if (both)        state_d = ST_BOTHWAIT;
				else if (!longp) state_d = only_dn ? ST_DNWAIT : ST_DN;
				else             state_d = only_dn ? ST_DNRAPID : ST_MWAIT;
			end
			ST_DN:      state_d = ST_MWAIT;
			ST_DNRAPID: state_d = only_dn ? ST_DNRAPID : ST_MWAIT;
			ST_BOTHWAIT: begin
				if (!both) state_d = ST_MWAIT;
				else       state_d = longp ? ST_SAVE : ST_BOTHWAIT;
			end
			ST_SAVE:     state_d = ST_SAVEHOLD;
			ST_SAVEHOLD: state_d = longp ? ST_MWAIT : ST_SAVEHOLD;
			default:     state_d = ST_MWAIT;
		endcase

		hold_d = hold_q;
		ev     = EV_NONE;
		adj    = '0;
		case (state_d)
			ST_INIT:  ev = EV_READ;
			ST_MWAIT: hold_d = '0;
			ST_UPWAIT, ST_DNWAIT, ST_BOTHWAIT, ST_SAVEHOLD: begin
				if (hold_q != HOLD_MAX) hold_d = hold_q + 1'b1;
			end
			ST_UP: begin
				ev  = EV_INC;
				adj = {1'b0, cfg.fine_step};
			end
			ST_UPRAPID: begin
				ev  = EV_INC;
				adj = {1'b0, cfg.coarse_step};
			end
			ST_DN: begin
				ev  = EV_DEC;
				adj = -{1'b0, cfg.fine_step};
			end
			ST_DNRAPID: begin
				ev  = EV_DEC;
				adj = -{1'b0, cfg.coarse_step};
			end
			ST_SAVE: begin
				ev     = EV_SAVE;
				hold_d = '0;
			end
			default: begin
			end
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			data_s2 <= {{(OUT_W-EVENT_W-ADJ_W-STATE_W){1'b0}}, state_d, adj, ev};
		end
	end

endmodule
